@@ hdl/uuenc_pkg.sv @@
package uuenc_pkg;

   // byte index width within one line buffer, one extra bit selects the bank
   localparam int CNT_W     = 6;
   localparam int ADDR_W    = CNT_W + 1;
   localparam int RAM_DEPTH = 2 ** ADDR_W;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [1:0] CMD_DATA    = 2'd0;
   localparam logic [1:0] CMD_FLUSH   = 2'd1;
   localparam logic [1:0] CMD_TRAILER = 2'd2;

   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_BQ    = 7'h60;
   localparam logic [6:0] CH_CR    = 7'h0D;
   localparam logic [6:0] CH_LF    = 7'h0A;
   localparam logic [6:0] CH_E     = 7'h65;
   localparam logic [6:0] CH_N     = 7'h6E;
   localparam logic [6:0] CH_D     = 7'h64;

   localparam logic [3:0] TRL_LAST = 4'd13;

   typedef enum logic {
      JOB_LINE,
      JOB_TRAILER
   } job_kind_type;

   typedef struct packed {
      job_kind_type     kind;
      logic [CNT_W-1:0] count;
      logic             bank;
      logic [15:0]      crc;
   } job_type;

   typedef struct packed {
      logic line_done;
   } back_status_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [6:0] six_char(input logic [5:0] v);
      logic [6:0] r;
      r = (v == 6'd0) ? CH_BQ : ({1'b0, v} + CH_SPACE);
      return r;
   endfunction

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] r;
      r = (nib < 4'd10) ? (7'h30 + {3'b000, nib}) : (7'h57 + {3'b000, nib});
      return r;
   endfunction

   // "`" CR LF "end" CR LF, four hex digits, CR LF
   function automatic logic [6:0] trailer_char(input logic [3:0] idx, input logic [15:0] crc);
      logic [6:0] r;
      case (idx)
         4'd0:    r = CH_BQ;
         4'd1:    r = CH_CR;
         4'd2:    r = CH_LF;
         4'd3:    r = CH_E;
         4'd4:    r = CH_N;
         4'd5:    r = CH_D;
         4'd6:    r = CH_CR;
         4'd7:    r = CH_LF;
         4'd8:    r = hex_char(crc[15:12]);
         4'd9:    r = hex_char(crc[11:8]);
         4'd10:   r = hex_char(crc[7:4]);
         4'd11:   r = hex_char(crc[3:0]);
         4'd12:   r = CH_CR;
         default: r = CH_LF;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/uuenc_ram.sv @@
module uuenc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/uuenc_front.sv @@
module uuenc_front #(
   parameter int LINE_BYTES = 45
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [1:0]                      in_cmd,
   input  logic [7:0]                      in_byte,
   input  logic                            queue_full,
   output logic                            push,
   output uuenc_pkg::job_type              push_job,
   output logic                            ram_we,
   output logic [uuenc_pkg::ADDR_W-1:0]    ram_waddr,
   output logic [7:0]                      ram_wdata,
   input  uuenc_pkg::back_status_type      back_status
);

   localparam logic [uuenc_pkg::CNT_W-1:0] FULL_COUNT = uuenc_pkg::CNT_W'(LINE_BYTES);

   logic [uuenc_pkg::CNT_W-1:0] count_ff, count_in;
   logic                        bank_ff, bank_in;
   logic [15:0]                 crc_ff, crc_in;
   // lines handed to the back end and not yet fully sent, one per bank
   logic [1:0]                  pend_ff, pend_in;
   logic                        accept;
   logic                        push_line;
   logic [uuenc_pkg::CNT_W-1:0] count_inc;

   assign in_ready  = !queue_full && (pend_ff != 2'd2);
   assign accept    = in_valid && in_ready;
   assign count_inc = count_ff + uuenc_pkg::CNT_W'(1);

   assign ram_waddr = {bank_ff, count_ff};
   assign ram_wdata = in_byte;

   always_comb begin
      count_in       = count_ff;
      bank_in        = bank_ff;
      crc_in         = crc_ff;
      push           = 1'b0;
      push_line      = 1'b0;
      ram_we         = 1'b0;
      push_job.kind  = uuenc_pkg::JOB_LINE;
      push_job.count = count_ff;
      push_job.bank  = bank_ff;
      push_job.crc   = crc_ff;
      if (accept) begin
         case (in_cmd)
            uuenc_pkg::CMD_DATA: begin
               crc_in = uuenc_pkg::crc_byte(crc_ff, in_byte);
               ram_we = 1'b1;
               if (count_inc == FULL_COUNT) begin
                  push           = 1'b1;
                  push_line      = 1'b1;
                  push_job.count = count_inc;
                  count_in       = '0;
                  bank_in        = !bank_ff;
               end else begin
                  count_in = count_inc;
               end
            end
            uuenc_pkg::CMD_FLUSH: begin
               if (count_ff != '0) begin
                  push      = 1'b1;
                  push_line = 1'b1;
                  count_in  = '0;
                  bank_in   = !bank_ff;
               end
            end
            uuenc_pkg::CMD_TRAILER: begin
               push          = 1'b1;
               push_job.kind = uuenc_pkg::JOB_TRAILER;
               crc_in        = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case ({push_line, back_status.line_done})
         2'b10:   pend_in = pend_ff + 2'd1;
         2'b01:   pend_in = pend_ff - 2'd1;
         default: pend_in = pend_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bank_ff  <= 1'b0;
         crc_ff   <= '0;
         pend_ff  <= '0;
      end else begin
         count_ff <= count_in;
         bank_ff  <= bank_in;
         crc_ff   <= crc_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

@@ hdl/uuenc_fifo.sv @@
module uuenc_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  uuenc_pkg::job_type wr_data,
   output logic               full,
   input  logic               pop,
   output logic               rd_valid,
   output uuenc_pkg::job_type rd_data
);

   localparam int PTR_W = $clog2(uuenc_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(uuenc_pkg::QUEUE_DEPTH + 1);

   uuenc_pkg::job_type slot_ff [uuenc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(uuenc_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(uuenc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(uuenc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/uuenc_back.sv @@
module uuenc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  uuenc_pkg::job_type           job,
   output logic                         job_pop,
   output logic                         ram_re,
   output logic [uuenc_pkg::ADDR_W-1:0] ram_raddr,
   input  logic [7:0]                   ram_rdata,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [6:0]                   out_char,
   output logic                         out_last,
   output uuenc_pkg::back_status_type   status
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_LEN  = 6'b000010,
      ST_DATA = 6'b000100,
      ST_CR   = 6'b001000,
      ST_LF   = 6'b010000,
      ST_TRL  = 6'b100000
   } back_state_type;

   back_state_type              state_ff, state_in;
   uuenc_pkg::job_type          job_ff, job_in;
   logic [uuenc_pkg::CNT_W-1:0] pos_ff, pos_in;
   logic [1:0]                  sub_ff, sub_in;
   logic [7:0]                  prev_ff, prev_in;
   logic [3:0]                  trl_idx_ff, trl_idx_in;
   logic                        out_valid_ff, out_valid_in;
   logic [6:0]                  out_char_ff, out_char_in;
   logic                        out_last_ff, out_last_in;

   logic                        slot_free;
   logic [uuenc_pkg::CNT_W:0]   cur_idx;
   logic [uuenc_pkg::CNT_W:0]   next_grp;
   logic [uuenc_pkg::CNT_W-1:0] rd_idx;
   logic [7:0]                  cur;

   assign slot_free = !out_valid_ff || out_ready;
   assign cur_idx   = {1'b0, pos_ff} + {{(uuenc_pkg::CNT_W - 1){1'b0}}, sub_ff};
   assign next_grp  = {1'b0, pos_ff} + (uuenc_pkg::CNT_W + 1)'(3);
   // bytes past the end of a partial line read as zero padding
   assign cur       = (cur_idx < {1'b0, job_ff.count}) ? ram_rdata : 8'h00;
   assign rd_idx    = (state_ff == ST_LEN) ? '0 : uuenc_pkg::CNT_W'(cur_idx + 1'b1);
   assign ram_raddr = {job_ff.bank, rd_idx};

   always_comb begin
      state_in         = state_ff;
      job_in           = job_ff;
      pos_in           = pos_ff;
      sub_in           = sub_ff;
      prev_in          = prev_ff;
      trl_idx_in       = trl_idx_ff;
      out_valid_in     = out_valid_ff && !out_ready;
      out_char_in      = out_char_ff;
      out_last_in      = out_last_ff;
      job_pop          = 1'b0;
      ram_re           = 1'b0;
      status.line_done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop    = 1'b1;
               job_in     = job;
               pos_in     = '0;
               sub_in     = '0;
               trl_idx_in = '0;
               state_in   = (job.kind == uuenc_pkg::JOB_LINE) ? ST_LEN : ST_TRL;
            end
         end
         ST_LEN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = {1'b0, job_ff.count} + uuenc_pkg::CH_SPACE;
               out_last_in  = 1'b0;
               ram_re       = 1'b1;
               state_in     = ST_DATA;
            end
         end
         ST_DATA: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_last_in  = 1'b0;
               sub_in       = sub_ff + 2'd1;
               case (sub_ff)
                  2'd0: begin
                     out_char_in = uuenc_pkg::six_char(cur[7:2]);
                     prev_in     = cur;
                     ram_re      = 1'b1;
                  end
                  2'd1: begin
                     out_char_in = uuenc_pkg::six_char({prev_ff[1:0], cur[7:4]});
                     prev_in     = cur;
                     ram_re      = 1'b1;
                  end
                  2'd2: begin
                     out_char_in = uuenc_pkg::six_char({prev_ff[3:0], cur[7:6]});
                     prev_in     = cur;
                     ram_re      = 1'b1;
                  end
                  default: begin
                     out_char_in = uuenc_pkg::six_char(prev_ff[5:0]);
                     if (next_grp >= {1'b0, job_ff.count}) begin
                        state_in = ST_CR;
                     end else begin
                        pos_in = next_grp[uuenc_pkg::CNT_W-1:0];
                     end
                  end
               endcase
            end
         end
         ST_CR: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = uuenc_pkg::CH_CR;
               out_last_in  = 1'b0;
               state_in     = ST_LF;
            end
         end
         ST_LF: begin
            if (slot_free) begin
               out_valid_in     = 1'b1;
               out_char_in      = uuenc_pkg::CH_LF;
               out_last_in      = 1'b1;
               status.line_done = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_TRL: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = uuenc_pkg::trailer_char(trl_idx_ff, job_ff.crc);
               out_last_in  = (trl_idx_ff == uuenc_pkg::TRL_LAST);
               trl_idx_in   = trl_idx_ff + 4'd1;
               if (trl_idx_ff == uuenc_pkg::TRL_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      pos_ff      <= pos_in;
      sub_ff      <= sub_in;
      prev_ff     <= prev_in;
      trl_idx_ff  <= trl_idx_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_char  = out_char_ff;
   assign out_last  = out_last_ff;

endmodule

@@ hdl/uuencode_line_encoder_crc16_unit.sv @@
// channel | ports                               | contents
// --------+-------------------------------------+-------------------------------------
// req     | req_tvalid req_tready req_tdata     | tdata[7:0] data_byte
//         | req_tuser                           | tuser[1:0] cmd (data, flush, trailer)
// rsp     | rsp_tvalid rsp_tready rsp_tdata     | tdata[6:0] out_char, tdata[7] zero
//         | rsp_tlast                           | tlast last char caused by one item
//
// an item is taken whenever req_tvalid and req_tready are both high; the front end stalls only while both line banks
// are still being sent or the two-entry job queue is full.
// the back end sends one char per cycle while rsp_tready allows, so a line of n bytes costs
// 4*ceil(n/3)+3 chars plus an idle start-up state, and a trailer 14 chars plus that idle state;
// sustained input is limited by that one-char-per-cycle output.
// synchronous reset clears counters, crc, queue and output; the line buffer is not cleared.
// rsp back-pressure holds the back end; the front end keeps taking items meanwhile until it stalls as above.
module uuencode_line_encoder_crc16_unit #(
   parameter int LINE_BYTES = 45
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] data_byte
   input  logic [1:0] req_tuser,  // [1:0] cmd
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [6:0] out_char, [7] zero
   output logic       rsp_tlast
);

   logic                            fifo_push;
   uuenc_pkg::job_type              fifo_wr_job;
   logic                            fifo_full;
   logic                            job_pop;
   logic                            job_valid;
   uuenc_pkg::job_type              job;
   logic                            ram_we;
   logic [uuenc_pkg::ADDR_W-1:0]    ram_waddr;
   logic [7:0]                      ram_wdata;
   logic                            ram_re;
   logic [uuenc_pkg::ADDR_W-1:0]    ram_raddr;
   logic [7:0]                      ram_rdata;
   uuenc_pkg::back_status_type      back_status;
   logic [6:0]                      out_char;

   uuenc_front #(
      .LINE_BYTES(LINE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_cmd     (req_tuser),
      .in_byte    (req_tdata),
      .queue_full (fifo_full),
      .push       (fifo_push),
      .push_job   (fifo_wr_job),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .back_status(back_status)
   );

   uuenc_ram #(
      .WIDTH(8),
      .DEPTH(uuenc_pkg::RAM_DEPTH)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   uuenc_fifo u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (fifo_push),
      .wr_data (fifo_wr_job),
      .full    (fifo_full),
      .pop     (job_pop),
      .rd_valid(job_valid),
      .rd_data (job)
   );

   uuenc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job_valid(job_valid),
      .job      (job),
      .job_pop  (job_pop),
      .ram_re   (ram_re),
      .ram_raddr(ram_raddr),
      .ram_rdata(ram_rdata),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_char (out_char),
      .out_last (rsp_tlast),
      .status   (back_status)
   );

   assign rsp_tdata = {1'b0, out_char};

`ifndef NO_ASSERTIONS
   // the front end must never hand a job to a full queue
   assert property (@(posedge clock) disable iff (reset) !(fifo_push && fifo_full))
      else $error("job pushed into full queue");

   // a line job always carries at least one byte
   assert property (@(posedge clock) disable iff (reset)
      (job_pop && job.kind == uuenc_pkg::JOB_LINE) |-> (job.count != '0))
      else $error("empty line job started");

   // every run of chars ends in a line feed
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[6:0] == uuenc_pkg::CH_LF))
      else $error("run ends on a char other than line feed");
`endif

endmodule

@@ tb/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_LEN = 45;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 300;
   localparam int DRAIN_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } enc_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic [1:0] req_tuser = 2'd0;    // [1:0] cmd
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [6:0] out_char, [7] zero
   logic       rsp_tlast;

   // encoder state as predicted
   logic [7:0] line_buf [LINE_LEN];
   int         line_fill;
   logic [15:0] crc_acc;
   enc_char_type expected_chars [$];
   enc_char_type step_chars [$];

   int error_count = 0;
   int item_count = 0;
   bit gaps_on = 1'b1;

   // directed stimulus table
   logic [1:0] row_cmd [$];
   logic [7:0] row_data [$];
   bit         row_typed [$];
   string      row_text [$];

   uuencode_line_encoder_crc16_unit #(
      .LINE_BYTES(LINE_LEN)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ uuenc_pkg::CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // zero maps to backquote so the text carries no spaces
   function automatic logic [6:0] enc6(input logic [5:0] v);
      return (v == 6'd0) ? uuenc_pkg::CH_BQ : ({1'b0, v} + uuenc_pkg::CH_SPACE);
   endfunction

   function automatic logic [6:0] hex_digit(input logic [3:0] nib);
      return (nib < 4'd10) ? (7'h30 + {3'b000, nib}) : (7'h61 + {3'b000, nib} - 7'd10);
   endfunction

   function automatic logic [7:0] rand_byte();
      int r;
      r = $urandom_range(7);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   task automatic push_char(input logic [6:0] ch);
      enc_char_type c;
      c.ch = ch;
      c.last = 1'b0;
      step_chars.push_back(c);
   endtask

   task automatic emit_line_chars();
      logic [7:0] b0, b1, b2;
      push_char(7'(line_fill) + uuenc_pkg::CH_SPACE);
      for (int i = 0; i < line_fill; i += 3) begin
         b0 = line_buf[i];
         b1 = (i + 1 < line_fill) ? line_buf[i + 1] : 8'h00;
         b2 = (i + 2 < line_fill) ? line_buf[i + 2] : 8'h00;
         push_char(enc6(b0[7:2]));
         push_char(enc6({b0[1:0], b1[7:4]}));
         push_char(enc6({b1[3:0], b2[7:6]}));
         push_char(enc6(b2[5:0]));
      end
      push_char(uuenc_pkg::CH_CR);
      push_char(uuenc_pkg::CH_LF);
      line_fill = 0;
   endtask

   task automatic encoder_step(input logic [1:0] cmd, input logic [7:0] b);
      enc_char_type c;
      step_chars.delete();
      case (cmd)
         uuenc_pkg::CMD_DATA: begin
            crc_acc = crc16_next(crc_acc, b);
            line_buf[line_fill] = b;
            line_fill++;
            if (line_fill >= LINE_LEN) emit_line_chars();
         end
         uuenc_pkg::CMD_FLUSH: begin
            if (line_fill != 0) emit_line_chars();
         end
         uuenc_pkg::CMD_TRAILER: begin
            // pending line bytes stay buffered
            push_char(uuenc_pkg::CH_BQ);
            push_char(uuenc_pkg::CH_CR);
            push_char(uuenc_pkg::CH_LF);
            push_char(uuenc_pkg::CH_E);
            push_char(uuenc_pkg::CH_N);
            push_char(uuenc_pkg::CH_D);
            push_char(uuenc_pkg::CH_CR);
            push_char(uuenc_pkg::CH_LF);
            push_char(hex_digit(crc_acc[15:12]));
            push_char(hex_digit(crc_acc[11:8]));
            push_char(hex_digit(crc_acc[7:4]));
            push_char(hex_digit(crc_acc[3:0]));
            push_char(uuenc_pkg::CH_CR);
            push_char(uuenc_pkg::CH_LF);
            crc_acc = 16'h0000;
         end
         default: ;
      endcase
      if (step_chars.size() > 0) begin
         c = step_chars.pop_back();
         c.last = 1'b1;
         step_chars.push_back(c);
      end
   endtask

   task automatic add_row(input logic [1:0] cmd, input logic [7:0] b, input bit typed,
                          input string txt);
      row_cmd.push_back(cmd);
      row_data.push_back(b);
      row_typed.push_back(typed);
      row_text.push_back(txt);
   endtask

   // typed rows take their expected text from txt, the rest from the predictor
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] b, input bit typed,
                            input string txt);
      enc_char_type c;
      byte ch8;
      if (gaps_on) begin
         while ($urandom_range(99) < 20) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      encoder_step(cmd, b);
      if (typed) begin
         for (int i = 0; i < txt.len(); i++) begin
            ch8 = txt[i];
            c.ch = ch8[6:0];
            c.last = (i == txt.len() - 1);
            expected_chars.push_back(c);
         end
      end else begin
         foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
      end
      if (cmd != CMD_UNUSED) item_count++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_tready <= !gaps_on || ($urandom_range(99) >= 20);
   end

   always @(posedge clock) begin : rsp_check
      enc_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            $display("%t unexpected char: got data %h last %b", $time, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tdata !== {1'b0, want.ch}) begin
               $display("%t char mismatch: expected %h, got %h", $time, {1'b0, want.ch},
                        rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%t last flag mismatch: expected %b, got %b", $time, want.last,
                        rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      int base;
      int n;
      int pick;
      int waited;
      bit paused;
      line_fill = 0;
      crc_acc = 16'h0000;
      paused = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(uuenc_pkg::CMD_FLUSH,   8'h00, 1'b1, "");
      add_row(uuenc_pkg::CMD_TRAILER, 8'h00, 1'b1, "\140\015\012end\015\0120000\015\012");
      add_row(CMD_UNUSED,             8'hFF, 1'b1, "");
      add_row(uuenc_pkg::CMD_DATA,    8'h00, 1'b1, "");
      add_row(uuenc_pkg::CMD_FLUSH,   8'h5A, 1'b1, "!\140\140\140\140\015\012");
      add_row(uuenc_pkg::CMD_DATA,    8'hFF, 1'b1, "");
      add_row(uuenc_pkg::CMD_FLUSH,   8'h00, 1'b1, "!_P\140\140\015\012");
      add_row(uuenc_pkg::CMD_FLUSH,   8'hFF, 1'b1, "");
      add_row(uuenc_pkg::CMD_TRAILER, 8'hA5, 1'b0, "");
      add_row(uuenc_pkg::CMD_DATA,    8'h01, 1'b0, "");
      add_row(uuenc_pkg::CMD_DATA,    8'h80, 1'b0, "");
      add_row(uuenc_pkg::CMD_DATA,    8'h7E, 1'b0, "");
      add_row(uuenc_pkg::CMD_FLUSH,   8'h00, 1'b0, "");
      add_row(uuenc_pkg::CMD_DATA,    8'h55, 1'b0, "");
      add_row(uuenc_pkg::CMD_DATA,    8'hAA, 1'b0, "");
      // trailer leaves the two bytes pending
      add_row(uuenc_pkg::CMD_TRAILER, 8'hFF, 1'b0, "");
      add_row(uuenc_pkg::CMD_DATA,    8'h3C, 1'b0, "");
      add_row(uuenc_pkg::CMD_DATA,    8'hC3, 1'b0, "");
      add_row(uuenc_pkg::CMD_DATA,    8'h0F, 1'b0, "");
      add_row(uuenc_pkg::CMD_DATA,    8'hF0, 1'b0, "");
      add_row(uuenc_pkg::CMD_FLUSH,   8'h81, 1'b0, "");
      add_row(CMD_UNUSED,             8'h00, 1'b1, "");
      add_row(uuenc_pkg::CMD_TRAILER, 8'h00, 1'b0, "");

      foreach (row_cmd[i]) send_item(row_cmd[i], row_data[i], row_typed[i], row_text[i]);
      wait_drained();

      base = item_count;
      while (item_count < base + RANDOM_ITEMS) begin
         gaps_on = !(item_count >= base + 120 && item_count < base + 220);
         pick = $urandom_range(9);
         if (pick < 5) begin
            n = LINE_LEN - line_fill;
            repeat (n) send_item(uuenc_pkg::CMD_DATA, rand_byte(), 1'b0, "");
            if ($urandom_range(2) == 0) begin
               send_item(uuenc_pkg::CMD_TRAILER, rand_byte(), 1'b0, "");
            end
         end else if (pick < 8) begin
            n = (line_fill < LINE_LEN - 1) ? $urandom_range(1, LINE_LEN - 1 - line_fill) : 0;
            repeat (n) send_item(uuenc_pkg::CMD_DATA, rand_byte(), 1'b0, "");
            send_item(uuenc_pkg::CMD_FLUSH, rand_byte(), 1'b0, "");
         end else if (pick == 8) begin
            repeat ($urandom_range(4)) send_item(uuenc_pkg::CMD_DATA, rand_byte(), 1'b0, "");
            send_item(uuenc_pkg::CMD_TRAILER, rand_byte(), 1'b0, "");
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_item(2'($urandom_range(3)), rand_byte(), 1'b0, "");
            end
         end
         // hold the sender until the output side has caught up
         if (!paused && item_count >= base + 250) begin
            wait_drained();
            paused = 1'b1;
         end
      end

      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_chars.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0) begin
         $display("%t %0d expected chars never arrived", $time, expected_chars.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
